// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the loader. They compile away when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/srl_pkg.sv =====
// ----------------------------------------------------------------------------
// S-record loader package
// Character codes, result kinds, parser phases and the records passed
// between the classifier, the parser and the queues.
// ----------------------------------------------------------------------------
package srl_pkg;

   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_3    = 8'h33;
   localparam logic [7:0] CH_7    = 8'h37;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_UA   = 8'h41;
   localparam logic [7:0] CH_UF   = 8'h46;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LF   = 8'h66;

   localparam logic [1:0] K_STORE = 2'd0;
   localparam logic [1:0] K_ROW   = 2'd1;
   localparam logic [1:0] K_DONE  = 2'd2;
   localparam logic [1:0] K_FATAL = 2'd3;

   localparam logic [2:0] SZ_NONE = 3'd0;
   localparam logic [2:0] SZ_BYTE = 3'd1;
   localparam logic [2:0] SZ_HALF = 3'd2;
   localparam logic [2:0] SZ_WORD = 3'd4;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_TYPE,
      PH_LEN,
      PH_SKIP,
      PH_ADDR,
      PH_DATA,
      PH_CSUM,
      PH_DONE,
      PH_HALT
   } phase_type;

   // One received character after classification.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic [3:0] nibble;
      logic       is_hex;
      logic       is_dec;
      logic       is_s;
   } char_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] store_address;
      logic [31:0] store_data;
      logic [2:0]  store_size;
      logic [15:0] row_number;
      logic [15:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic [2:0] size;
      logic [3:0] digits;
      phase_type  phase;
   } chunk_type;

   // Parser status toward the top level.
   typedef struct packed {
      logic    take;
      logic    push;
      logic    terminal;
      rsp_type rsp;
   } back_status_type;

endpackage

// ===== rtl/srecord_loader.sv =====
// A result can be popped once the character that completes it has passed
// through the character queue and then the result queue. Throughput: one
// character per cycle while the result queue has room; characters that give
// no result take no extra time. Reset (synchronous, active high) empties
// both queues and returns the parser to the hunt for 'S' with the row
// counter at one.
// ----------------------------------------------------------------------------
// S-record loader
// Character classifier and queue in front, record parser and result queue
// behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srecord_loader #(
   parameter int ADDR_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_store_address,
   output logic [31:0] rsp_store_data,
   output logic [2:0]  rsp_store_size,
   output logic [15:0] rsp_row_number,
   output logic [15:0] rsp_error_code
);
   import srl_pkg::*;

   char_type        front_item;
   char_type        queued_item;
   logic            item_empty;
   logic            rsp_full;
   back_status_type back_status;
   rsp_type         rsp_head;
   logic            store_push;
   logic            size_legal;

   srl_front u_front (
      .rx_byte (req_rx_byte),
      .item    (front_item)
   );

   srl_queue #(
      .WIDTH ($bits(char_type)),
      .DEPTH (2)
   ) u_char_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (back_status.take),
      .rd_data (queued_item),
      .empty   (item_empty)
   );

   srl_back #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (queued_item),
      .item_empty (item_empty),
      .rsp_full   (rsp_full),
      .status     (back_status)
   );

   srl_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_status.push),
      .wr_data (back_status.rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head),
      .empty   (rsp_empty)
   );

   assign rsp_kind          = rsp_head.kind;
   assign rsp_store_address = rsp_head.store_address;
   assign rsp_store_data    = rsp_head.store_data;
   assign rsp_store_size    = rsp_head.store_size;
   assign rsp_row_number    = rsp_head.row_number;
   assign rsp_error_code    = rsp_head.error_code;

   assign store_push = back_status.push && (back_status.rsp.kind == K_STORE);
   assign size_legal = (back_status.rsp.store_size == SZ_BYTE) ||
                       (back_status.rsp.store_size == SZ_HALF) ||
                       (back_status.rsp.store_size == SZ_WORD);

   // Once finished or halted, the parser never produces another result.
   `ASSERT_NEXT(a_terminal_quiet, clock, reset, back_status.terminal, !back_status.push)
   // A store result always carries a legal width.
   `ASSERT_IMPLIES(a_store_size, clock, reset, store_push, size_legal)
   // The parser only steps while the result queue has room.
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, back_status.push, !rsp_full && !item_empty)
   // A result appears only after the parser pushed one.
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $fell(rsp_empty), $past(back_status.push))

endmodule

// ===== rtl/srl_queue.sv =====
// ----------------------------------------------------------------------------
// Loader queue
// Small register queue with full and empty flags; the head entry is shown
// on the read port while the queue is not empty.
// ----------------------------------------------------------------------------
module srl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/srl_front.sv =====
// ----------------------------------------------------------------------------
// Loader character classifier
// Decodes each received character into its hex value and the flags the
// parser tests, before it enters the character queue.
// ----------------------------------------------------------------------------
module srl_front (
   input  logic [7:0]       rx_byte,
   output srl_pkg::char_type item
);
   import srl_pkg::*;

   always_comb begin
      item         = '0;
      item.rx_byte = rx_byte;
      item.is_s    = (rx_byte == CH_S);
      item.is_dec  = (rx_byte inside {[CH_0:CH_9]});
      if (rx_byte inside {[CH_0:CH_9]}) begin
         item.is_hex = 1'b1;
         item.nibble = 4'(rx_byte - CH_0);
      end else if (rx_byte inside {[CH_UA:CH_UF]}) begin
         item.is_hex = 1'b1;
         item.nibble = 4'(rx_byte - CH_UA + 8'd10);
      end else if (rx_byte inside {[CH_LA:CH_LF]}) begin
         item.is_hex = 1'b1;
         item.nibble = 4'(rx_byte - CH_LA + 8'd10);
      end
   end

endmodule

// ===== rtl/srl_back.sv =====
// ----------------------------------------------------------------------------
// Loader record parser
// Walks the record structure one classified character at a time and
// produces store, row, finish and halt results.
// ----------------------------------------------------------------------------
module srl_back #(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srl_pkg::char_type        item,
   input  logic                     item_empty,
   input  logic                     rsp_full,
   output srl_pkg::back_status_type status
);
   import srl_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [3:0]            digits_ff, digits_in;
   logic [31:0]           acc_ff, acc_in;
   logic [7:0]            rkind_ff, rkind_in;
   logic [15:0]           remain_ff, remain_in;
   logic [ADDR_WIDTH-1:0] wptr_ff, wptr_in;
   logic [15:0]           row_ff, row_in;
   logic [2:0]            psize_ff, psize_in;

   logic                  take;
   logic [31:0]           digit32;
   logic [31:0]           acc_shift;
   logic [3:0]            digits_dec;
   logic [15:0]           len;
   logic [15:0]           remain_data;
   logic [31:0]           data_masked;
   chunk_type             chunk;

   // Picks the next store size from the signed count of data bytes left.
   function automatic chunk_type pick_chunk(input logic [15:0] left);
      chunk_type c;
      if ($signed(left) > 16'sd4) begin
         c = '{size: SZ_WORD, digits: 4'd8, phase: PH_DATA};
      end else if ($signed(left) > 16'sd2) begin
         c = '{size: SZ_HALF, digits: 4'd4, phase: PH_DATA};
      end else if ($signed(left) > 16'sd1) begin
         c = '{size: SZ_BYTE, digits: 4'd2, phase: PH_DATA};
      end else begin
         c = '{size: SZ_NONE, digits: 4'd2, phase: PH_CSUM};
      end
      return c;
   endfunction

   assign take       = !item_empty && !rsp_full;
   // A character that is not a hex digit counts as minus one.
   assign digit32    = item.is_hex ? {28'd0, item.nibble} : 32'hFFFF_FFFF;
   assign acc_shift  = {acc_ff[27:0], 4'd0} + digit32;
   assign digits_dec = (digits_ff != 4'd0) ? digits_ff - 4'd1 : 4'd0;
   assign len        = acc_shift[15:0];
   assign remain_data = remain_ff - {13'd0, psize_ff};

   always_comb begin
      data_masked = acc_shift;
      if (psize_ff == SZ_HALF) begin
         data_masked = {16'd0, acc_shift[15:0]};
      end else if (psize_ff == SZ_BYTE) begin
         data_masked = {24'd0, acc_shift[7:0]};
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      rkind_in  = rkind_ff;
      remain_in = remain_ff;
      wptr_in   = wptr_ff;
      row_in    = row_ff;
      psize_in  = psize_ff;
      chunk     = pick_chunk(remain_ff);

      status                = '0;
      status.take           = take;
      status.terminal       = (phase_ff == PH_DONE) || (phase_ff == PH_HALT);
      status.rsp.row_number = row_ff;

      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (item.is_s) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               rkind_in = item.rx_byte;
               if (!item.is_dec) begin
                  phase_in              = PH_HALT;
                  status.push           = 1'b1;
                  status.rsp.kind       = K_FATAL;
                  status.rsp.error_code = {item.rx_byte, 8'd0} + row_ff;
               end else begin
                  phase_in  = PH_LEN;
                  digits_in = 4'd2;
                  acc_in    = '0;
               end
            end
            PH_LEN: begin
               acc_in    = acc_shift;
               digits_in = digits_dec;
               if (digits_dec == 4'd0) begin
                  status.push = 1'b1;
                  case (rkind_ff)
                     CH_0: begin
                        remain_in       = {len[14:0], 1'b0};
                        status.rsp.kind = K_ROW;
                        if (len[14:0] == 15'd0) begin
                           row_in   = row_ff + 16'd1;
                           phase_in = PH_HUNT;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                     CH_3: begin
                        remain_in       = len - 16'd4;
                        phase_in        = PH_ADDR;
                        digits_in       = 4'd8;
                        acc_in          = '0;
                        status.rsp.kind = K_ROW;
                     end
                     CH_7: begin
                        remain_in = {len[14:0], 1'b0};
                        if (len[14:0] == 15'd0) begin
                           phase_in        = PH_DONE;
                           status.rsp.kind = K_DONE;
                        end else begin
                           phase_in        = PH_SKIP;
                           status.rsp.kind = K_ROW;
                        end
                     end
                     CH_9: begin
                        phase_in        = PH_DONE;
                        status.rsp.kind = K_DONE;
                     end
                     default: begin
                        phase_in              = PH_HALT;
                        status.rsp.kind       = K_FATAL;
                        status.rsp.error_code = {rkind_ff, 8'd0} + row_ff;
                     end
                  endcase
               end
            end
            PH_SKIP: begin
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  if (rkind_ff == CH_7) begin
                     phase_in        = PH_DONE;
                     status.push     = 1'b1;
                     status.rsp.kind = K_DONE;
                  end else begin
                     row_in   = row_ff + 16'd1;
                     phase_in = PH_HUNT;
                  end
               end
            end
            PH_ADDR: begin
               acc_in    = acc_shift;
               digits_in = digits_dec;
               if (digits_dec == 4'd0) begin
                  wptr_in   = acc_shift[ADDR_WIDTH-1:0];
                  acc_in    = '0;
                  psize_in  = chunk.size;
                  digits_in = chunk.digits;
                  phase_in  = chunk.phase;
               end
            end
            PH_DATA: begin
               acc_in    = acc_shift;
               digits_in = digits_dec;
               if (digits_dec == 4'd0) begin
                  status.push              = 1'b1;
                  status.rsp.kind          = K_STORE;
                  status.rsp.store_address = 32'(wptr_ff);
                  status.rsp.store_data    = data_masked;
                  status.rsp.store_size    = psize_ff;
                  wptr_in   = wptr_ff + ADDR_WIDTH'(psize_ff);
                  remain_in = remain_data;
                  chunk     = pick_chunk(remain_data);
                  acc_in    = '0;
                  psize_in  = chunk.size;
                  digits_in = chunk.digits;
                  phase_in  = chunk.phase;
               end
            end
            PH_CSUM: begin
               digits_in = digits_dec;
               if (digits_dec == 4'd0) begin
                  row_in   = row_ff + 16'd1;
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               // Finished or halted: characters are dropped.
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         digits_ff <= '0;
         acc_ff    <= '0;
         rkind_ff  <= '0;
         remain_ff <= '0;
         wptr_ff   <= '0;
         row_ff    <= 16'd1;
         psize_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
         rkind_ff  <= rkind_in;
         remain_ff <= remain_in;
         wptr_ff   <= wptr_in;
         row_ff    <= row_in;
         psize_ff  <= psize_in;
      end
   end

endmodule

// ===== sim/tb_srecord_loader.sv =====
// ----------------------------------------------------------------------------
// S-record loader testbench
// Feeds S0 and S3 records, stray characters and damaged records into the
// loader one character per transfer, predicts every store, row and end
// result with a behavioral parser of its own, and compares each popped
// result with the oldest prediction. The run closes with one randomly
// chosen ending record (S9, S7 or a bad record type), since the loader
// ignores everything after it until reset.
// ----------------------------------------------------------------------------
module tb_srecord_loader;
   import srl_pkg::*;

   localparam int ADDR_WIDTH    = 32;
   localparam int RANDOM_ITEMS  = 700;
   localparam int HOLD_CYCLES   = 1500;
   localparam int STALL_LIMIT   = 8000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [63:0] ADDR_SPAN = 64'd1 << ADDR_WIDTH;
   localparam logic [31:0] ADDR_MASK = ADDR_SPAN[31:0] - 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_store_address;
   logic [31:0] rsp_store_data;
   logic [2:0]  rsp_store_size;
   logic [15:0] rsp_row_number;
   logic [15:0] rsp_error_code;

   // Parser state as the loader should hold it.
   phase_type   ld_phase = PH_HUNT;
   logic [3:0]  ld_digits = 4'd0;
   logic [31:0] ld_acc = 32'd0;
   logic [7:0]  ld_type = 8'd0;
   logic [15:0] ld_remaining = 16'd0;
   logic [31:0] ld_pointer = 32'd0;
   logic [15:0] ld_row = 16'd1;
   logic [2:0]  ld_chunk = SZ_NONE;

   rsp_type expected_q [$];
   int      error_count = 0;
   int      used_items = 0;
   int      burst_left = 0;
   bit      hold_request = 1'b0;
   bit      final_drain = 1'b0;

   typedef struct {
      string   text;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   // A typed result belongs to the last character of its row.
   directed_row_type directed_rows [7] = '{
      '{"\377", 1'b0, '0},
      '{"S000", 1'b1, rsp_type'{K_ROW, 32'd0, 32'd0, SZ_NONE, 16'd1, 16'd0}},
      '{"S306", 1'b1, rsp_type'{K_ROW, 32'd0, 32'd0, SZ_NONE, 16'd2, 16'd0}},
      '{"FFFFFFFF", 1'b0, '0},
      '{"ab", 1'b1, rsp_type'{K_STORE, 32'hFFFF_FFFF, 32'h0000_00AB, SZ_BYTE, 16'd2, 16'd0}},
      '{"zz", 1'b0, '0},
      '{"S001Sx", 1'b0, '0}
   };

   srecord_loader #(
      .ADDR_WIDTH(ADDR_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_rx_byte(req_rx_byte),
      .req_full(req_full),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_kind(rsp_kind),
      .rsp_store_address(rsp_store_address),
      .rsp_store_data(rsp_store_data),
      .rsp_store_size(rsp_store_size),
      .rsp_row_number(rsp_row_number),
      .rsp_error_code(rsp_error_code)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] hex_value(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
      if (c >= CH_UA && c <= CH_UF) return 32'(c - CH_UA + 10);
      if (c >= CH_LA && c <= CH_LF) return 32'(c - CH_LA + 10);
      return '1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_0 + n;
      return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + n - 10);
   endfunction

   // Any character that is neither a hex digit nor the record mark.
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: c = 8'h00;
         1: c = 8'hFF;
         default: c = 8'($urandom_range(0, 255));
      endcase
      while (c == CH_S || hex_value(c) != '1) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic rsp_type loader_rsp(input logic [1:0] kind, input logic [31:0] addr,
                                          input logic [31:0] data, input logic [2:0] size,
                                          input logic [15:0] err);
      return rsp_type'{kind, addr, data, size, ld_row, err};
   endfunction

   function automatic void take_digit(input logic [7:0] c);
      ld_acc = (ld_acc << 4) + hex_value(c);
      if (ld_digits > 0) ld_digits--;
   endfunction

   function automatic void end_record();
      ld_row = ld_row + 16'd1;
      ld_phase = PH_HUNT;
   endfunction

   // Picks the widest store that still leaves the checksum byte behind.
   function automatic void next_chunk();
      logic signed [15:0] left;
      left = signed'(ld_remaining);
      ld_acc = 32'd0;
      if (left > 4) begin
         ld_chunk = SZ_WORD; ld_digits = 4'd8; ld_phase = PH_DATA;
      end else if (left > 2) begin
         ld_chunk = SZ_HALF; ld_digits = 4'd4; ld_phase = PH_DATA;
      end else if (left > 1) begin
         ld_chunk = SZ_BYTE; ld_digits = 4'd2; ld_phase = PH_DATA;
      end else begin
         ld_chunk = SZ_NONE; ld_digits = 4'd2; ld_phase = PH_CSUM;
      end
   endfunction

   // Advances the parser by one character; returns 1 when a result is due.
   function automatic bit parse_char(input logic [7:0] c, output rsp_type r);
      logic [15:0] err;
      logic [15:0] len;
      logic [2:0]  size;
      logic [31:0] addr;
      logic [31:0] data;
      r = '0;
      err = {ld_type, 8'h00} + ld_row;
      case (ld_phase)
         PH_HUNT: begin
            if (c == CH_S) ld_phase = PH_TYPE;
            return 1'b0;
         end
         PH_TYPE: begin
            ld_type = c;
            if (c < CH_0 || c > CH_9) begin
               ld_phase = PH_HALT;
               r = loader_rsp(K_FATAL, 32'd0, 32'd0, SZ_NONE, {c, 8'h00} + ld_row);
               return 1'b1;
            end
            ld_phase = PH_LEN;
            ld_digits = 4'd2;
            ld_acc = 32'd0;
            return 1'b0;
         end
         PH_LEN: begin
            take_digit(c);
            if (ld_digits != 0) return 1'b0;
            len = ld_acc[15:0];
            case (ld_type)
               CH_0: begin
                  ld_remaining = len << 1;
                  r = loader_rsp(K_ROW, 32'd0, 32'd0, SZ_NONE, 16'd0);
                  if (ld_remaining == 0) end_record();
                  else ld_phase = PH_SKIP;
               end
               CH_3: begin
                  ld_remaining = len - 16'd4;
                  ld_phase = PH_ADDR;
                  ld_digits = 4'd8;
                  ld_acc = 32'd0;
                  r = loader_rsp(K_ROW, 32'd0, 32'd0, SZ_NONE, 16'd0);
               end
               CH_7: begin
                  ld_remaining = len << 1;
                  if (ld_remaining == 0) begin
                     ld_phase = PH_DONE;
                     r = loader_rsp(K_DONE, 32'd0, 32'd0, SZ_NONE, 16'd0);
                  end else begin
                     ld_phase = PH_SKIP;
                     r = loader_rsp(K_ROW, 32'd0, 32'd0, SZ_NONE, 16'd0);
                  end
               end
               CH_9: begin
                  ld_phase = PH_DONE;
                  r = loader_rsp(K_DONE, 32'd0, 32'd0, SZ_NONE, 16'd0);
               end
               default: begin
                  ld_phase = PH_HALT;
                  r = loader_rsp(K_FATAL, 32'd0, 32'd0, SZ_NONE, err);
               end
            endcase
            return 1'b1;
         end
         PH_SKIP: begin
            ld_remaining = ld_remaining - 16'd1;
            if (ld_remaining != 0) return 1'b0;
            if (ld_type == CH_7) begin
               ld_phase = PH_DONE;
               r = loader_rsp(K_DONE, 32'd0, 32'd0, SZ_NONE, 16'd0);
               return 1'b1;
            end
            end_record();
            return 1'b0;
         end
         PH_ADDR: begin
            take_digit(c);
            if (ld_digits != 0) return 1'b0;
            ld_pointer = ld_acc & ADDR_MASK;
            next_chunk();
            return 1'b0;
         end
         PH_DATA: begin
            size = ld_chunk;
            addr = ld_pointer & ADDR_MASK;
            take_digit(c);
            if (ld_digits != 0) return 1'b0;
            data = ld_acc;
            if (size == SZ_HALF) data = data & 32'h0000_FFFF;
            else if (size == SZ_BYTE) data = data & 32'h0000_00FF;
            r = loader_rsp(K_STORE, addr, data, size, 16'd0);
            ld_pointer = (ld_pointer + size) & ADDR_MASK;
            ld_remaining = ld_remaining - size;
            next_chunk();
            return 1'b1;
         end
         PH_CSUM: begin
            if (ld_digits > 0) ld_digits--;
            if (ld_digits == 0) end_record();
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // One character transfer, with the sender's burst and gap pattern in front.
   task automatic push_char(input logic [7:0] c, input bit typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type r;
      bit      produced;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (req_full);
      // Characters dropped during the hunt do not count as work.
      if (ld_phase != PH_HUNT || c == CH_S) used_items++;
      produced = parse_char(c, r);
      if (typed) expected_q.push_back(want);
      else if (produced) expected_q.push_back(r);
   endtask

   task automatic send_random_record();
      int          choice;
      int          n;
      int          count;
      int          d1;
      logic [31:0] where;
      choice = $urandom_range(0, 99);
      if (choice < 10) begin
         repeat ($urandom_range(1, 6)) push_char(junk_char());
      end else if (choice < 35) begin
         push_char(CH_S);
         push_char(CH_0);
         if ($urandom_range(0, 9) == 0) begin
            // A junk low digit counts as minus one, so the length is 16*d1-1.
            d1 = $urandom_range(1, 3);
            push_char(hex_char(4'(d1)));
            push_char(junk_char());
            n = 16 * d1 - 1;
         end else begin
            n = $urandom_range(0, 12);
            push_char(hex_char(4'(n >> 4)));
            push_char(hex_char(4'(n)));
         end
         repeat (2 * n)
            push_char($urandom_range(0, 1) ? junk_char() : hex_char(4'($urandom_range(0, 15))));
      end else begin
         push_char(CH_S);
         push_char(CH_3);
         choice = $urandom_range(0, 99);
         if (choice < 4) begin
            // Junk in the length makes it negative: only the checksum follows.
            if ($urandom_range(0, 1)) begin
               push_char(junk_char());
               push_char(hex_char(4'($urandom_range(0, 15))));
            end else begin
               push_char(CH_0);
               push_char(junk_char());
            end
            count = 2;
         end else begin
            n = (choice < 6) ? $urandom_range(25, 255) : $urandom_range(0, 24);
            push_char(hex_char(4'(n >> 4)));
            push_char(hex_char(4'(n)));
            count = (n - 4 > 1) ? 2 * (n - 4) : 2;
         end
         case ($urandom_range(0, 9))
            0: where = 32'h0000_0000;
            1: where = 32'hFFFF_FFFF;
            default: where = $urandom;
         endcase
         for (int i = 7; i >= 0; i--) push_char(hex_char(where[4*i +: 4]));
         // Now and then the record is cut short and the next one is eaten as data.
         if ($urandom_range(0, 11) == 0) count = $urandom_range(0, count - 1);
         repeat (count)
            push_char(($urandom_range(0, 24) == 0) ? junk_char()
                                                   : hex_char(4'($urandom_range(0, 15))));
      end
   endtask

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%s: expected kind %0d addr %h data %h size %0d row %0d err %h",
                  what, want.kind, want.store_address, want.store_data, want.store_size,
                  want.row_number, want.error_code);
         $display("   got kind %0d addr %h data %h size %0d row %0d err %h",
                  got.kind, got.store_address, got.store_data, got.store_size,
                  got.row_number, got.error_code);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = rsp_type'{rsp_kind, rsp_store_address, rsp_store_data, rsp_store_size,
                         rsp_row_number, rsp_error_code};
         if (expected_q.size() == 0) begin
            note_failure("unexpected result", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) note_failure("result mismatch", want, got);
         end
      end
   end

   // The receiver alternates pop rates in windows, and holds off for a long
   // stretch once when asked so that the loader backs up into its input.
   initial begin : receiver
      int hold_left;
      int window;
      int rate;
      hold_left = 0;
      window = 0;
      rate = 100;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (window == 0) begin
            window = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: rate = 100;
               1: rate = 75;
               2: rate = 40;
               default: rate = 10;
            endcase
         end
         window--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= final_drain || ($urandom_range(1, 100) <= rate);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      bit         hold_asked;
      bit         paused;
      string      bad_digits;
      logic [7:0] c;
      hold_asked = 1'b0;
      paused = 1'b0;
      bad_digits = "124568";
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         for (int i = 0; i < directed_rows[r].text.len(); i++)
            push_char(directed_rows[r].text[i],
                      directed_rows[r].typed && i == directed_rows[r].text.len() - 1,
                      directed_rows[r].want);

      while (used_items < RANDOM_ITEMS) begin
         if (!hold_asked && used_items >= 200) begin
            hold_asked = 1'b1;
            hold_request = 1'b1;
         end
         if (!paused && used_items >= 450) begin
            paused = 1'b1;
            req_push <= 1'b0;
            do @(posedge clock); while (expected_q.size() != 0);
         end
         send_random_record();
      end

      // Bring the parser back to the hunt before the ending record.
      while (ld_phase != PH_HUNT) push_char(hex_char(4'($urandom_range(0, 15))));
      push_char(CH_S);
      case ($urandom_range(0, 5))
         0: begin
            push_char(CH_9);
            push_char(CH_0);
            push_char(CH_3);
         end
         1: begin
            push_char(CH_7);
            push_char(CH_0);
            push_char(CH_0);
         end
         2: begin
            push_char(CH_7);
            push_char(CH_0);
            push_char(hex_char(4'd2));
            repeat (4) push_char(junk_char());
         end
         3: begin
            // A junk low length digit counts as minus one: a length of 15, so 30 are skipped.
            push_char(CH_7);
            push_char(hex_char(4'd1));
            push_char(junk_char());
            repeat (30) push_char(junk_char());
         end
         4: begin
            c = 8'($urandom_range(0, 255));
            while (c >= CH_0 && c <= CH_9) c = 8'($urandom_range(0, 255));
            push_char(c);
         end
         default: begin
            push_char(bad_digits[$urandom_range(0, 5)]);
            push_char(hex_char(4'($urandom_range(0, 15))));
            push_char(hex_char(4'($urandom_range(0, 15))));
         end
      endcase
      // The loader has stopped; these must give nothing.
      repeat (16) push_char(8'($urandom_range(0, 255)));
      req_push <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      final_drain = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== srecord_loader.f =====
+incdir+rtl
rtl/srl_pkg.sv
rtl/srl_queue.sv
rtl/srl_front.sv
rtl/srl_back.sv
rtl/srecord_loader.sv
sim/tb_srecord_loader.sv
